FILE: sv/pur_pkg.sv
// pur_pkg: shared types, codes and constants for the picture unit register
// and vblank timing core. Used by every module in sv/.
package pur_pkg;

    localparam int OP_W    = 2;
    localparam int REG_W   = 3;
    localparam int REQ_W   = 2;
    localparam int CNT_W   = 9;
    localparam int VADDR_W = 14;
    localparam int BYTE_W  = 8;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_RETURN = 2'd3;

    localparam logic [REG_W-1:0] REG_CTRL     = 3'd0;
    localparam logic [REG_W-1:0] REG_MASK     = 3'd1;
    localparam logic [REG_W-1:0] REG_STATUS   = 3'd2;
    localparam logic [REG_W-1:0] REG_OAM_ADDR = 3'd3;
    localparam logic [REG_W-1:0] REG_OAM_DATA = 3'd4;
    localparam logic [REG_W-1:0] REG_SCROLL   = 3'd5;
    localparam logic [REG_W-1:0] REG_ADDR     = 3'd6;
    localparam logic [REG_W-1:0] REG_DATA     = 3'd7;

    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

    localparam int DOTS_DEFAULT         = 341;
    localparam int LINES_DEFAULT        = 262;
    localparam int SPRITE_BYTES_DEFAULT = 256;

    localparam int EVT_DOT          = 1;
    localparam int LINE_FRAME_START = 240;
    localparam int LINE_VBLANK_SET  = 241;
    localparam int LINE_VBLANK_CLR  = 261;

    localparam int CTRL_NMI_BIT = 7;
    localparam int CTRL_INC_BIT = 2;
    localparam int STEP_WIDE    = 32;
    localparam int STEP_NARROW  = 1;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_byte;
        logic               nmi_pulse;
        logic               frame_start;
        logic [REQ_W-1:0]   mem_request;
        logic [VADDR_W-1:0] mem_address;
        logic [BYTE_W-1:0]  mem_write_byte;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] data;
    } t_spr_wr;

endpackage

FILE: sv/pur_spram.sv
// pur_spram: sprite byte store, one write and one registered read per cycle,
// with per-entry valid bits so unwritten entries read as zero. Uses pur_pkg.
module pur_spram #(
    parameter int SPRITE_BYTES = pur_pkg::SPRITE_BYTES_DEFAULT,
    localparam int IDX_W = $clog2(SPRITE_BYTES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pur_pkg::t_spr_wr          i_wr,
    input  logic [IDX_W-1:0]          i_wr_idx,
    input  logic [IDX_W-1:0]          i_rd_idx,
    output logic [pur_pkg::BYTE_W-1:0] o_rd_data
);

    logic [pur_pkg::BYTE_W-1:0] r_mem [SPRITE_BYTES];
    logic [SPRITE_BYTES-1:0]    r_valid;
    logic [pur_pkg::BYTE_W-1:0] r_rd_data;
    logic                       r_rd_vld;
    logic                       rd_hit;

    // read of the entry being written returns the new byte
    assign rd_hit = i_wr.en && (i_wr_idx == i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_idx] <= i_wr.data;
        end
        if (rd_hit) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_idx] || rd_hit;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: sv/pur_core.sv
// pur_core: register file, dot/line counters and per-request decode.
// Produces one result per processed request. Uses pur_pkg.
module pur_core #(
    parameter int DOTS_PER_LINE   = pur_pkg::DOTS_DEFAULT,
    parameter int LINES_PER_FRAME = pur_pkg::LINES_DEFAULT,
    parameter int SPRITE_BYTES    = pur_pkg::SPRITE_BYTES_DEFAULT,
    localparam int IDX_W = $clog2(SPRITE_BYTES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [pur_pkg::OP_W-1:0]    i_op,
    input  logic [pur_pkg::REG_W-1:0]   i_reg_index,
    input  logic [pur_pkg::BYTE_W-1:0]  i_write_byte,
    input  logic [pur_pkg::BYTE_W-1:0]  i_return_byte,
    input  logic [pur_pkg::BYTE_W-1:0]  i_spr_rdata,
    output pur_pkg::t_result            o_result,
    output pur_pkg::t_spr_wr            o_spr_wr,
    output logic [IDX_W-1:0]            o_spr_wr_idx,
    output logic [IDX_W-1:0]            o_spr_rd_idx
);

    localparam int CW = pur_pkg::CNT_W;
    localparam int VW = pur_pkg::VADDR_W;
    localparam int BW = pur_pkg::BYTE_W;

    // mask and scroll registers have no visible effect and are not kept
    logic [CW-1:0] r_dot, n_dot;
    logic [CW-1:0] r_line, n_line;
    logic [BW-1:0] r_ctrl, n_ctrl;
    logic          r_vblank, n_vblank;
    logic [BW-1:0] r_spr_addr, n_spr_addr;
    logic [VW-1:0] r_vaddr, n_vaddr;
    logic          r_addr_tgl, n_addr_tgl;
    logic [BW-1:0] r_rbuf, n_rbuf;

    logic [IDX_W-1:0] spr_idx_tbl [1 << BW];
    logic [CW:0]      dot_inc;
    logic [CW:0]      line_inc;
    logic [VW-1:0]    vaddr_adv;

    for (genvar g = 0; g < (1 << BW); g++) begin : g_idx
        assign spr_idx_tbl[g] = IDX_W'(g % SPRITE_BYTES);
    end

    assign dot_inc   = {1'b0, r_dot} + (CW+1)'(1);
    assign line_inc  = {1'b0, r_line} + (CW+1)'(1);
    assign vaddr_adv = r_vaddr + (r_ctrl[pur_pkg::CTRL_INC_BIT] ?
                       VW'(pur_pkg::STEP_WIDE) : VW'(pur_pkg::STEP_NARROW));

    always_comb begin
        n_dot      = r_dot;
        n_line     = r_line;
        n_ctrl     = r_ctrl;
        n_vblank   = r_vblank;
        n_spr_addr = r_spr_addr;
        n_vaddr    = r_vaddr;
        n_addr_tgl = r_addr_tgl;
        n_rbuf     = r_rbuf;
        o_result   = '0;
        o_spr_wr   = '0;
        if (i_fire) begin
            case (i_op)
                pur_pkg::OP_TICK: begin
                    if (r_dot == CW'(pur_pkg::EVT_DOT)) begin
                        if (r_line == CW'(pur_pkg::LINE_FRAME_START)) begin
                            o_result.frame_start = 1'b1;
                        end
                        if (r_line == CW'(pur_pkg::LINE_VBLANK_SET)) begin
                            o_result.nmi_pulse = r_ctrl[pur_pkg::CTRL_NMI_BIT];
                            n_vblank           = 1'b1;
                        end
                        if (r_line == CW'(pur_pkg::LINE_VBLANK_CLR)) begin
                            n_vblank = 1'b0;
                        end
                    end
                    if (dot_inc >= (CW+1)'(DOTS_PER_LINE)) begin
                        n_dot = '0;
                        if (line_inc >= (CW+1)'(LINES_PER_FRAME)) begin
                            n_line = '0;
                        end else begin
                            n_line = line_inc[CW-1:0];
                        end
                    end else begin
                        n_dot = dot_inc[CW-1:0];
                    end
                end
                pur_pkg::OP_WRITE: begin
                    case (i_reg_index)
                        pur_pkg::REG_CTRL: begin
                            n_ctrl = i_write_byte;
                        end
                        pur_pkg::REG_OAM_ADDR: begin
                            n_spr_addr = i_write_byte;
                        end
                        pur_pkg::REG_OAM_DATA: begin
                            o_spr_wr.en   = 1'b1;
                            o_spr_wr.data = i_write_byte;
                            n_spr_addr    = r_spr_addr + BW'(1);
                        end
                        pur_pkg::REG_ADDR: begin
                            if (!r_addr_tgl) begin
                                n_vaddr = {i_write_byte[VW-BW-1:0], BW'(0)};
                            end else begin
                                n_vaddr = {r_vaddr[VW-1:BW], i_write_byte};
                            end
                            n_addr_tgl = ~r_addr_tgl;
                        end
                        pur_pkg::REG_DATA: begin
                            o_result.mem_request    = pur_pkg::REQ_WRITE;
                            o_result.mem_address    = r_vaddr;
                            o_result.mem_write_byte = i_write_byte;
                            n_vaddr                 = vaddr_adv;
                        end
                        default: ;
                    endcase
                end
                pur_pkg::OP_READ: begin
                    case (i_reg_index)
                        pur_pkg::REG_STATUS: begin
                            o_result.read_byte = {r_vblank, (BW-1)'(0)};
                            n_vblank           = 1'b0;
                            n_addr_tgl         = 1'b0;
                        end
                        pur_pkg::REG_OAM_DATA: begin
                            o_result.read_byte = i_spr_rdata;
                        end
                        pur_pkg::REG_DATA: begin
                            o_result.read_byte   = r_rbuf;
                            o_result.mem_request = pur_pkg::REQ_READ;
                            o_result.mem_address = r_vaddr;
                            n_vaddr              = vaddr_adv;
                        end
                        default: ;
                    endcase
                end
                pur_pkg::OP_RETURN: begin
                    n_rbuf = i_return_byte;
                end
                default: ;
            endcase
        end
    end

    assign o_spr_wr_idx = spr_idx_tbl[r_spr_addr];
    assign o_spr_rd_idx = spr_idx_tbl[n_spr_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot      <= '0;
            r_line     <= '0;
            r_ctrl     <= '0;
            r_vblank   <= 1'b0;
            r_spr_addr <= '0;
            r_vaddr    <= '0;
            r_addr_tgl <= 1'b0;
            r_rbuf     <= '0;
        end else begin
            r_dot      <= n_dot;
            r_line     <= n_line;
            r_ctrl     <= n_ctrl;
            r_vblank   <= n_vblank;
            r_spr_addr <= n_spr_addr;
            r_vaddr    <= n_vaddr;
            r_addr_tgl <= n_addr_tgl;
            r_rbuf     <= n_rbuf;
        end
    end

`ifndef SYNTHESIS
    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_dot) < DOTS_PER_LINE)
        else $error("dot counter out of range");
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_line) < LINES_PER_FRAME)
        else $error("line counter out of range");
    a_tick_keeps_vaddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_op == pur_pkg::OP_TICK |=> $stable(r_vaddr))
        else $error("video address moved on a tick");
`endif

endmodule

FILE: sv/picture_unit_register_and_vblank_timing_core.sv
// picture_unit_register_and_vblank_timing_core: top level with input and
// result registers around pur_core and pur_spram. Uses pur_pkg.
//
// Usage:
//  Input channel (i_valid/o_ready) carries one request: a dot tick, a
//  register write, a register read or a video memory return byte.
//  Output channel (o_valid/i_ready) carries exactly one result per request,
//  in order: read data, NMI and frame-start pulses and a video memory
//  request (address and write data).
//  An accepted request waits in the input register and is processed into the
//  result register. Throughput: one request per cycle while the receiver does
//  not stall. The sprite store read port is addressed with the next sprite
//  address every cycle, so sprite reads also complete in that single pass.
//  Reset (synchronous, active low) clears counters, registers, toggles,
//  the read buffer and the sprite store valid bits; no clearing pass.
//  When the receiver stalls, the result register holds and one more
//  request can wait in the input register; o_ready then drops.
module picture_unit_register_and_vblank_timing_core #(
    parameter int DOTS_PER_LINE   = pur_pkg::DOTS_DEFAULT,
    parameter int LINES_PER_FRAME = pur_pkg::LINES_DEFAULT,
    parameter int SPRITE_BYTES    = pur_pkg::SPRITE_BYTES_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pur_pkg::OP_W-1:0]     i_op,
    input  logic [pur_pkg::REG_W-1:0]    i_reg_index,
    input  logic [pur_pkg::BYTE_W-1:0]   i_write_byte,
    input  logic [pur_pkg::BYTE_W-1:0]   i_return_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pur_pkg::BYTE_W-1:0]   o_read_byte,
    output logic                         o_nmi_pulse,
    output logic                         o_frame_start,
    output logic [pur_pkg::REQ_W-1:0]    o_mem_request,
    output logic [pur_pkg::VADDR_W-1:0]  o_mem_address,
    output logic [pur_pkg::BYTE_W-1:0]   o_mem_write_byte
);

    localparam int IDX_W = $clog2(SPRITE_BYTES);

    logic                        r_in_vld;
    logic [pur_pkg::OP_W-1:0]    r_op;
    logic [pur_pkg::REG_W-1:0]   r_reg_index;
    logic [pur_pkg::BYTE_W-1:0]  r_write_byte;
    logic [pur_pkg::BYTE_W-1:0]  r_return_byte;
    logic                        r_out_vld;
    pur_pkg::t_result            r_out;

    logic                        fire;
    logic                        accept;
    pur_pkg::t_result            result;
    pur_pkg::t_spr_wr            spr_wr;
    logic [IDX_W-1:0]            spr_wr_idx;
    logic [IDX_W-1:0]            spr_rd_idx;
    logic [pur_pkg::BYTE_W-1:0]  spr_rdata;

    assign fire    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || fire;
    assign accept  = i_valid && o_ready;

    pur_core #(
        .DOTS_PER_LINE   (DOTS_PER_LINE),
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .SPRITE_BYTES    (SPRITE_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_op          (r_op),
        .i_reg_index   (r_reg_index),
        .i_write_byte  (r_write_byte),
        .i_return_byte (r_return_byte),
        .i_spr_rdata   (spr_rdata),
        .o_result      (result),
        .o_spr_wr      (spr_wr),
        .o_spr_wr_idx  (spr_wr_idx),
        .o_spr_rd_idx  (spr_rd_idx)
    );

    pur_spram #(
        .SPRITE_BYTES (SPRITE_BYTES)
    ) u_spram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (spr_wr),
        .i_wr_idx  (spr_wr_idx),
        .i_rd_idx  (spr_rd_idx),
        .o_rd_data (spr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op          <= i_op;
            r_reg_index   <= i_reg_index;
            r_write_byte  <= i_write_byte;
            r_return_byte <= i_return_byte;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_read_byte      = r_out.read_byte;
    assign o_nmi_pulse      = r_out.nmi_pulse;
    assign o_frame_start    = r_out.frame_start;
    assign o_mem_request    = r_out.mem_request;
    assign o_mem_address    = r_out.mem_address;
    assign o_mem_write_byte = r_out.mem_write_byte;

`ifndef SYNTHESIS
    a_no_req_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mem_request == pur_pkg::REQ_NONE |-> o_mem_address == '0)
        else $error("address without a memory request");
    a_wdata_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mem_request != pur_pkg::REQ_WRITE |-> o_mem_write_byte == '0)
        else $error("write data without a write request");
    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_nmi_pulse && o_frame_start))
        else $error("NMI and frame start in one result");
`endif

endmodule
